// ===== design/oan_pkg.sv =====
// Package for the obstacle-avoidance navigation controller.
// Shared codes, configuration defaults and control structs; no dependencies.
package oan_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DIST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TURN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURNS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STUCK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_MS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_MS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_BASE  = 3'd7;

  // navigation states
  localparam logic [3:0] ST_FWD        = 4'd0;
  localparam logic [3:0] ST_BACK       = 4'd1;
  localparam logic [3:0] ST_LEFT       = 4'd2;
  localparam logic [3:0] ST_RIGHT      = 4'd3;
  localparam logic [3:0] ST_HEAD_LEFT  = 4'd4;
  localparam logic [3:0] ST_HEAD_RIGHT = 4'd5;
  localparam logic [3:0] ST_HEAD_CTR   = 4'd6;
  localparam logic [3:0] ST_MEASURE    = 4'd7;
  localparam logic [3:0] ST_WHICH_WAY  = 4'd8;
  localparam logic [3:0] ST_STUCK_FWD  = 4'd9;
  localparam logic [3:0] ST_STUCK_BACK = 4'd10;
  localparam logic [3:0] ST_DLY_FWD    = 4'd11;
  localparam logic [3:0] ST_DLY_BWD    = 4'd12;
  localparam logic [3:0] ST_ERROR      = 4'd13;

  // drive / head command codes
  localparam logic [3:0] DRV_HOLD       = 4'd0;
  localparam logic [3:0] DRV_STOP       = 4'd1;
  localparam logic [3:0] DRV_FWD        = 4'd2;
  localparam logic [3:0] DRV_BACK       = 4'd3;
  localparam logic [3:0] DRV_FWD_LEFT   = 4'd4;
  localparam logic [3:0] DRV_FWD_RIGHT  = 4'd5;
  localparam logic [3:0] DRV_HEAD_LEFT  = 4'd6;
  localparam logic [3:0] DRV_HEAD_RIGHT = 4'd7;
  localparam logic [3:0] DRV_HEAD_CTR   = 4'd8;

  // scan targets
  localparam logic [1:0] SCAN_NONE  = 2'd0;
  localparam logic [1:0] SCAN_LEFT  = 2'd1;
  localparam logic [1:0] SCAN_RIGHT = 2'd2;
  localparam logic [1:0] SCAN_CTR   = 2'd3;

  // fixed head and stop timings, ms
  localparam logic [15:0] HEAD_LEFT_MS  = 16'd300;
  localparam logic [15:0] HEAD_RIGHT_MS = 16'd600;
  localparam logic [15:0] HEAD_CTR_MS   = 16'd300;
  localparam logic [15:0] STOP_DELAY_MS = 16'd200;

  localparam logic [3:0] TURN_SAT = 4'd15;

  typedef struct packed {
    logic [11:0] stop_distance;
    logic [11:0] min_turn_distance;
    logic [3:0]  max_turn_count;
    logic [2:0]  max_stuck_steps;
    logic [15:0] check_period_ms;
    logic [15:0] backup_ms;
    logic [15:0] turn_ms;
    logic [12:0] stuck_base_ms;
  } oan_cfg_t;

  localparam oan_cfg_t CFG_RESET = '{
    stop_distance:     12'd30,
    min_turn_distance: 12'd15,
    max_turn_count:    4'd5,
    max_stuck_steps:   3'd5,
    check_period_ms:   16'd200,
    backup_ms:         16'd1000,
    turn_ms:           16'd1000,
    stuck_base_ms:     13'd500
  };

  typedef struct packed {
    logic [3:0] nav_state;
    logic [1:0] scan_target;
    logic [3:0] left_turns;
    logic [3:0] right_turns;
    logic [2:0] fwd_mult;
    logic [2:0] back_mult;
  } oan_ctrl_t;

endpackage

// ===== design/oan_in_if.sv =====
// Input word channel of the navigation controller: valid/ready plus tick payload.
// No dependencies.
interface oan_in_if #(parameter int RANGE_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [7:0]            elapsed_ms;
  logic [RANGE_BITS-1:0] range_cm;
  logic                  stuck;

  modport source (output valid, cmd, elapsed_ms, range_cm, stuck, input ready);
  modport sink   (input valid, cmd, elapsed_ms, range_cm, stuck, output ready);
endinterface

// ===== design/oan_out_if.sv =====
// Result word channel of the navigation controller: valid/ready plus command codes.
// No dependencies.
interface oan_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] drive_code;
  logic [3:0] state_code;

  modport source (output valid, drive_code, state_code, input ready);
  modport sink   (input valid, drive_code, state_code, output ready);
endinterface

// ===== design/obstacle_avoid_nav_fsm_unit.sv =====
// Top level of the obstacle-avoidance navigation controller.
// Depends on oan_pkg, oan_in_if, oan_out_if, oan_cfg_regs, oan_step.
//
// Usage:
//  - in_ch carries one word per navigation tick: cmd (0 tick, 1 restart),
//    elapsed_ms, range_cm and the stuck flag. A word is taken when valid and
//    ready are both high at a rising edge of clk.
//  - out_ch returns one word per input word: drive_code (motor or head
//    command) and state_code (navigation state after the tick), in order.
//  - cfg_we/cfg_idx/cfg_wdata write the eight settings registers; write
//    them only while no word is in flight.
//  - A word taken passes through the input register, then the next-state
//    logic into the output register, from which it shows up on out_ch.
//  - One word per cycle while the receiver does not stall; the navigation
//    state is updated in the same edge that loads the output register, so
//    consecutive ticks chain with no bubble.
//  - If the receiver stalls, the output register holds its word and the input
//    register still takes one more word; in_ch.ready then drops until
//    out_ch.ready returns.
//  - Reset (rst_n low, synchronous) empties both registers, puts the state
//    machine in forward travel with timer, ranges and turn counts at zero,
//    multipliers at one and settings at their default values.
module obstacle_avoid_nav_fsm_unit import oan_pkg::*; #(
  parameter int RANGE_BITS = 12,
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  oan_in_if.sink                in_ch,
  oan_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  oan_cfg_t cfg;

  oan_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  logic                  s1_valid_r;
  logic                  s1_cmd_r;
  logic [7:0]            s1_elapsed_r;
  logic [RANGE_BITS-1:0] s1_range_r;
  logic                  s1_stuck_r;

  // navigation state
  oan_ctrl_t             ctrl_r, ctrl_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [RANGE_BITS-1:0] left_r, left_nxt;
  logic [RANGE_BITS-1:0] right_r, right_nxt;
  logic [RANGE_BITS-1:0] center_r, center_nxt;
  logic [3:0]            drive_nxt;

  // output register
  logic       out_valid_r;
  logic [3:0] out_drive_r;
  logic [3:0] out_state_r;

  logic adv;     // input register word moves to the output register
  logic in_take;

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  oan_step #(
    .RANGE_BITS (RANGE_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cfg          (cfg),
    .ctrl         (ctrl_r),
    .timer        (timer_r),
    .left_range   (left_r),
    .right_range  (right_r),
    .center_range (center_r),
    .cmd          (s1_cmd_r),
    .elapsed_ms   (s1_elapsed_r),
    .range_cm     (s1_range_r),
    .stuck        (s1_stuck_r),
    .ctrl_nxt     (ctrl_nxt),
    .timer_nxt    (timer_nxt),
    .left_nxt     (left_nxt),
    .right_nxt    (right_nxt),
    .center_nxt   (center_nxt),
    .drive_code   (drive_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctrl_r      <= '{nav_state: ST_FWD, scan_target: SCAN_NONE, left_turns: 4'd0,
                       right_turns: 4'd0, fwd_mult: 3'd1, back_mult: 3'd1};
      timer_r     <= '0;
      left_r      <= '0;
      right_r     <= '0;
      center_r    <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        ctrl_r      <= ctrl_nxt;
        timer_r     <= timer_nxt;
        left_r      <= left_nxt;
        right_r     <= right_nxt;
        center_r    <= center_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r     <= in_ch.cmd;
      s1_elapsed_r <= in_ch.elapsed_ms;
      s1_range_r   <= in_ch.range_cm;
      s1_stuck_r   <= in_ch.stuck;
    end
    if (adv) begin
      out_drive_r <= drive_nxt;
      out_state_r <= ctrl_nxt.nav_state;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.drive_code = out_drive_r;
  assign out_ch.state_code = out_state_r;

`ifndef SYNTH
  // a word that leaves the input register always lands in the output register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced word did not reach output register");

  // a stalled output word is never overwritten
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !adv)
    else $error("output word overwritten during stall");

  // the state machine never rests in an unused code
  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.nav_state <= ST_ERROR)
    else $error("navigation state left the legal range");

  // a restart always returns to forward travel with a hold command
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_cmd_r) |=> (out_state_r == ST_FWD && out_drive_r == DRV_HOLD))
    else $error("restart did not return to forward travel");
`endif

endmodule

// ===== design/oan_cfg_regs.sv =====
// Configuration register file for the navigation controller.
// Depends on oan_pkg.
module oan_cfg_regs import oan_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output oan_cfg_t              cfg
);

  oan_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_STOP_DIST:  cfg_nxt.stop_distance     = cfg_wdata[11:0];
        CFG_MIN_TURN:   cfg_nxt.min_turn_distance = cfg_wdata[11:0];
        CFG_MAX_TURNS:  cfg_nxt.max_turn_count    = cfg_wdata[3:0];
        CFG_MAX_STUCK:  cfg_nxt.max_stuck_steps   = cfg_wdata[2:0];
        CFG_CHECK_MS:   cfg_nxt.check_period_ms   = cfg_wdata[15:0];
        CFG_BACKUP_MS:  cfg_nxt.backup_ms         = cfg_wdata[15:0];
        CFG_TURN_MS:    cfg_nxt.turn_ms           = cfg_wdata[15:0];
        CFG_STUCK_BASE: cfg_nxt.stuck_base_ms     = cfg_wdata[12:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/oan_step.sv =====
// Next-state logic of the navigation controller: one tick, timer, ranges, counters.
// Depends on oan_pkg.
module oan_step import oan_pkg::*; #(
  parameter int RANGE_BITS = 12,
  parameter int TIMER_BITS = 16
) (
  input  oan_cfg_t              cfg,
  input  oan_ctrl_t             ctrl,
  input  logic [TIMER_BITS-1:0] timer,
  input  logic [RANGE_BITS-1:0] left_range,
  input  logic [RANGE_BITS-1:0] right_range,
  input  logic [RANGE_BITS-1:0] center_range,
  input  logic                  cmd,
  input  logic [7:0]            elapsed_ms,
  input  logic [RANGE_BITS-1:0] range_cm,
  input  logic                  stuck,
  output oan_ctrl_t             ctrl_nxt,
  output logic [TIMER_BITS-1:0] timer_nxt,
  output logic [RANGE_BITS-1:0] left_nxt,
  output logic [RANGE_BITS-1:0] right_nxt,
  output logic [RANGE_BITS-1:0] center_nxt,
  output logic [3:0]            drive_code
);

  // compare widths
  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam int RW = (RANGE_BITS > 12) ? RANGE_BITS : 12;

  logic [TIMER_BITS:0]   sum;
  logic [TIMER_BITS-1:0] t;
  logic [CW-1:0]         t_cw;
  logic [15:0]           fwd_limit, back_limit;
  logic [RW-1:0]         rng_w, left_w, right_w, ctr_w, stop_w, min_w;
  logic                  check_due;
  logic [3:0]            fwd_bump, back_bump;

  assign sum  = {1'b0, timer} + (TIMER_BITS+1)'(elapsed_ms);
  assign t    = sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
  assign t_cw = CW'(t);

  assign fwd_limit  = 16'(cfg.stuck_base_ms * ctrl.fwd_mult);
  assign back_limit = 16'(cfg.stuck_base_ms * ctrl.back_mult);

  assign rng_w   = RW'(range_cm);
  assign left_w  = RW'(left_range);
  assign right_w = RW'(right_range);
  assign ctr_w   = RW'(center_range);
  assign stop_w  = RW'(cfg.stop_distance);
  assign min_w   = RW'(cfg.min_turn_distance);

  assign check_due = t_cw >= CW'(cfg.check_period_ms);

  // multiplier bump, capped at max_stuck_steps
  assign fwd_bump  = ({1'b0, ctrl.fwd_mult} + 4'd1 > {1'b0, cfg.max_stuck_steps}) ?
                     {1'b0, cfg.max_stuck_steps} : {1'b0, ctrl.fwd_mult} + 4'd1;
  assign back_bump = ({1'b0, ctrl.back_mult} + 4'd1 > {1'b0, cfg.max_stuck_steps}) ?
                     {1'b0, cfg.max_stuck_steps} : {1'b0, ctrl.back_mult} + 4'd1;

  always_comb begin
    ctrl_nxt   = ctrl;
    timer_nxt  = t;
    left_nxt   = left_range;
    right_nxt  = right_range;
    center_nxt = center_range;
    drive_code = DRV_HOLD;

    if (cmd) begin
      ctrl_nxt.nav_state   = ST_FWD;
      ctrl_nxt.left_turns  = '0;
      ctrl_nxt.right_turns = '0;
      ctrl_nxt.fwd_mult    = 3'd1;
      ctrl_nxt.back_mult   = 3'd1;
    end else begin
      unique case (ctrl.nav_state)
        ST_FWD: begin
          if (check_due && (rng_w < stop_w)) begin
            drive_code = DRV_STOP; ctrl_nxt.nav_state = ST_DLY_FWD; timer_nxt = '0;
          end else if (stuck) begin
            drive_code = DRV_STOP; ctrl_nxt.nav_state = ST_STUCK_FWD; timer_nxt = '0;
          end else begin
            drive_code = DRV_FWD;
            ctrl_nxt.fwd_mult  = 3'd1;
            ctrl_nxt.back_mult = 3'd1;
            if (check_due) timer_nxt = '0;
          end
        end
        ST_BACK: begin
          if (t_cw >= CW'(cfg.backup_ms)) begin
            drive_code = DRV_STOP; ctrl_nxt.nav_state = ST_DLY_BWD; timer_nxt = '0;
          end else if (stuck) begin
            drive_code = DRV_STOP; ctrl_nxt.nav_state = ST_STUCK_BACK; timer_nxt = '0;
          end else begin
            drive_code = DRV_BACK;
            ctrl_nxt.fwd_mult  = 3'd1;
            ctrl_nxt.back_mult = 3'd1;
          end
        end
        ST_LEFT, ST_RIGHT: begin
          if (t_cw >= CW'(cfg.turn_ms)) begin
            ctrl_nxt.nav_state = ST_FWD; timer_nxt = '0;
          end else begin
            drive_code = (ctrl.nav_state == ST_LEFT) ? DRV_FWD_LEFT : DRV_FWD_RIGHT;
          end
        end
        ST_HEAD_LEFT: begin
          if (t_cw >= CW'(HEAD_LEFT_MS)) begin
            drive_code = DRV_STOP; ctrl_nxt.scan_target = SCAN_LEFT;
            ctrl_nxt.nav_state = ST_MEASURE; timer_nxt = '0;
          end else drive_code = DRV_HEAD_LEFT;
        end
        ST_HEAD_RIGHT: begin
          if (t_cw >= CW'(HEAD_RIGHT_MS)) begin
            drive_code = DRV_STOP; ctrl_nxt.scan_target = SCAN_RIGHT;
            ctrl_nxt.nav_state = ST_MEASURE; timer_nxt = '0;
          end else drive_code = DRV_HEAD_RIGHT;
        end
        ST_HEAD_CTR: begin
          if (t_cw >= CW'(HEAD_CTR_MS)) begin
            drive_code = DRV_STOP; ctrl_nxt.scan_target = SCAN_CTR;
            ctrl_nxt.nav_state = ST_MEASURE; timer_nxt = '0;
          end else drive_code = DRV_HEAD_CTR;
        end
        ST_MEASURE: begin
          unique case (ctrl.scan_target)
            SCAN_LEFT: begin
              left_nxt = range_cm; ctrl_nxt.nav_state = ST_HEAD_RIGHT; timer_nxt = '0;
            end
            SCAN_RIGHT: begin
              right_nxt = range_cm; ctrl_nxt.nav_state = ST_HEAD_CTR; timer_nxt = '0;
            end
            SCAN_CTR: begin
              center_nxt = range_cm; ctrl_nxt.nav_state = ST_WHICH_WAY; timer_nxt = '0;
            end
            default: ctrl_nxt.nav_state = ST_ERROR;
          endcase
        end
        ST_WHICH_WAY: begin
          timer_nxt = '0;
          priority if ((ctrl.right_turns > cfg.max_turn_count) ||
                       (ctrl.left_turns > cfg.max_turn_count)) begin
            ctrl_nxt.right_turns = '0;
            ctrl_nxt.left_turns  = '0;
            ctrl_nxt.nav_state   = ST_BACK;
          end else if (ctr_w < min_w) begin
            ctrl_nxt.nav_state = ST_BACK;
          end else if ((left_w < min_w) && (right_w < min_w)) begin
            ctrl_nxt.nav_state = ST_BACK;
          end else if (left_w >= right_w) begin
            ctrl_nxt.nav_state = ST_LEFT;
            if (ctrl.left_turns < TURN_SAT) ctrl_nxt.left_turns = ctrl.left_turns + 4'd1;
          end else begin
            ctrl_nxt.nav_state = ST_RIGHT;
            if (ctrl.right_turns < TURN_SAT) ctrl_nxt.right_turns = ctrl.right_turns + 4'd1;
          end
        end
        ST_STUCK_FWD: begin
          if (t_cw >= CW'(fwd_limit)) begin
            ctrl_nxt.fwd_mult = fwd_bump[2:0]; ctrl_nxt.nav_state = ST_BACK; timer_nxt = '0;
          end else drive_code = DRV_BACK;
        end
        ST_STUCK_BACK: begin
          if (t_cw >= CW'(back_limit)) begin
            ctrl_nxt.back_mult = back_bump[2:0]; ctrl_nxt.nav_state = ST_FWD; timer_nxt = '0;
          end else drive_code = DRV_FWD;
        end
        ST_DLY_FWD, ST_DLY_BWD: begin
          if (t_cw >= CW'(STOP_DELAY_MS)) begin
            ctrl_nxt.nav_state = ST_HEAD_LEFT; timer_nxt = '0;
          end
        end
        default: begin
          // error state and unused codes: stop and restart navigation
          drive_code           = DRV_STOP;
          ctrl_nxt.nav_state   = ST_FWD;
          ctrl_nxt.left_turns  = '0;
          ctrl_nxt.right_turns = '0;
          ctrl_nxt.fwd_mult    = 3'd1;
          ctrl_nxt.back_mult   = 3'd1;
        end
      endcase
    end
  end

endmodule
